// ===== src/hts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the hysteresis thermostat.
// Used by hts_front, hts_back and the top level; depends on nothing else.
package hts_pkg;

   localparam int TEMP_W     = 16;
   localparam int LIMIT_W    = 12;
   localparam int DELAY_S_W  = 16;
   localparam int DELAY_MS_W = 26;
   localparam int TIME_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MS_PER_S   = 1000;

   localparam logic signed [TEMP_W-1:0] SETPOINT_RESET = 16'sd320;
   localparam logic [LIMIT_W-1:0]       BAND_RESET     = 12'd8;
   localparam logic [LIMIT_W-1:0]       LIMIT_RESET    = 12'd80;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE        = 3'd0,
      CSR_PROBE       = 3'd1,
      CSR_CHAMBER_EN  = 3'd2,
      CSR_SETPOINT    = 3'd3,
      CSR_BAND        = 3'd4,
      CSR_LIMIT       = 3'd5,
      CSR_HEAT_DELAY  = 3'd6,
      CSR_COOL_DELAY  = 3'd7
   } csr_addr_type;

   typedef enum logic [1:0] {
      MODE_NONE       = 2'd0,
      MODE_UNSUP      = 2'd1,
      MODE_THERMOSTAT = 2'd2,
      MODE_RESERVED   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PROBE_BEER     = 2'd0,
      PROBE_CHAMBER  = 2'd1,
      PROBE_OTHER    = 2'd2,
      PROBE_RESERVED = 2'd3
   } probe_type;

   typedef enum logic [2:0] {
      STATUS_NONE    = 3'd0,
      STATUS_IDLE    = 3'd1,
      STATUS_HEATING = 3'd2,
      STATUS_COOLING = 3'd3,
      STATUS_FAULT   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      REASON_NO_CONFIG  = 4'd0,
      REASON_MODE       = 4'd1,
      REASON_MISSING    = 4'd2,
      REASON_INVALID    = 4'd3,
      REASON_STALE      = 4'd4,
      REASON_BAND       = 4'd5,
      REASON_BELOW      = 4'd6,
      REASON_HEAT_DELAY = 4'd7,
      REASON_HIGH_LIMIT = 4'd8,
      REASON_ABOVE      = 4'd9,
      REASON_COOL_DELAY = 4'd10,
      REASON_LOW_LIMIT  = 4'd11,
      REASON_EXCLUSION  = 4'd12
   } reason_type;

   typedef enum logic [2:0] {
      FAULT_NONE            = 3'd0,
      FAULT_MODE            = 3'd1,
      FAULT_BEER_MISSING    = 3'd2,
      FAULT_BEER_INVALID    = 3'd3,
      FAULT_BEER_STALE      = 3'd4,
      FAULT_CHAMBER_MISSING = 3'd5,
      FAULT_CHAMBER_INVALID = 3'd6,
      FAULT_CHAMBER_STALE   = 3'd7
   } fault_type;

   typedef struct packed {
      logic [TIME_W-1:0]        now_ms;
      logic                     beer_present;
      logic                     beer_ok;
      logic                     beer_stale;
      logic signed [TEMP_W-1:0] beer_temp;
      logic                     chamber_present;
      logic                     chamber_ok;
      logic                     chamber_stale;
      logic signed [TEMP_W-1:0] chamber_temp;
      logic                     heat_switch_ok;
      logic                     cool_switch_ok;
   } req_type;

   // Classified tick, handed from the front end to the relay stage
   typedef struct packed {
      logic [TIME_W-1:0]     now_ms;
      fault_type             fault;
      reason_type            reason;
      status_type            status;
      logic                  auto_active;
      logic                  heat_req;
      logic                  cool_req;
      logic                  heat_block;
      logic                  cool_block;
      logic [DELAY_MS_W-1:0] heat_delay_ms;
      logic [DELAY_MS_W-1:0] cool_delay_ms;
      logic                  heat_switch_ok;
      logic                  cool_switch_ok;
   } cls_type;

   typedef struct packed {
      logic       heat_command;
      logic       cool_command;
      logic       heater_active;
      logic       cooler_active;
      logic       auto_active;
      status_type status_code;
      reason_type reason_code;
      fault_type  fault_code;
   } rsp_type;

endpackage

// ===== src/hts_queue.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue of register slots.
// Generic; no package dependency.
module hts_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/hts_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, mode and probe checks, band and limit demand.
// Depends on hts_pkg.
module hts_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [hts_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [hts_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  hts_pkg::req_type                   req,
   output hts_pkg::cls_type                   cls
);

   hts_pkg::mode_type                   mode_ff;
   hts_pkg::probe_type                  probe_ff;
   logic                                chamber_en_ff;
   logic signed [hts_pkg::TEMP_W-1:0]   setpoint_ff;
   logic [hts_pkg::LIMIT_W-1:0]         band_ff;
   logic [hts_pkg::LIMIT_W-1:0]         limit_ff;
   logic [hts_pkg::DELAY_S_W-1:0]       heat_delay_ff;
   logic [hts_pkg::DELAY_S_W-1:0]       cool_delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= hts_pkg::MODE_NONE;
         probe_ff      <= hts_pkg::PROBE_BEER;
         chamber_en_ff <= 1'b0;
         setpoint_ff   <= hts_pkg::SETPOINT_RESET;
         band_ff       <= hts_pkg::BAND_RESET;
         limit_ff      <= hts_pkg::LIMIT_RESET;
         heat_delay_ff <= '0;
         cool_delay_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            hts_pkg::CSR_MODE:       mode_ff       <= hts_pkg::mode_type'(csr_wr_data[1:0]);
            hts_pkg::CSR_PROBE:      probe_ff      <= hts_pkg::probe_type'(csr_wr_data[1:0]);
            hts_pkg::CSR_CHAMBER_EN: chamber_en_ff <= csr_wr_data[0];
            hts_pkg::CSR_SETPOINT:   setpoint_ff   <= signed'(csr_wr_data);
            hts_pkg::CSR_BAND:       band_ff       <= csr_wr_data[hts_pkg::LIMIT_W-1:0];
            hts_pkg::CSR_LIMIT:      limit_ff      <= csr_wr_data[hts_pkg::LIMIT_W-1:0];
            hts_pkg::CSR_HEAT_DELAY: heat_delay_ff <= csr_wr_data;
            hts_pkg::CSR_COOL_DELAY: cool_delay_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   logic                              use_chamber;
   logic                              p_present;
   logic                              p_ok;
   logic                              p_stale;
   logic signed [hts_pkg::TEMP_W-1:0] p_temp;
   logic signed [17:0]                sp_x;
   logic signed [17:0]                band_x;
   logic signed [17:0]                limit_x;
   logic signed [17:0]                temp_x;
   logic signed [17:0]                ch_x;
   logic                              heat_dem;
   logic                              cool_dem;
   logic                              limit_on;

   always_comb begin
      use_chamber = (probe_ff == hts_pkg::PROBE_CHAMBER) && chamber_en_ff;
      p_present   = use_chamber ? req.chamber_present : req.beer_present;
      p_ok        = use_chamber ? req.chamber_ok      : req.beer_ok;
      p_stale     = use_chamber ? req.chamber_stale   : req.beer_stale;
      p_temp      = use_chamber ? req.chamber_temp    : req.beer_temp;

      sp_x    = 18'(setpoint_ff);
      band_x  = signed'({6'b0, band_ff});
      limit_x = signed'({6'b0, limit_ff});
      temp_x  = 18'(p_temp);
      ch_x    = 18'(req.chamber_temp);

      heat_dem = temp_x < (sp_x - band_x);
      cool_dem = temp_x > (sp_x + band_x);
      limit_on = (probe_ff == hts_pkg::PROBE_BEER) && chamber_en_ff &&
                 req.chamber_present && req.chamber_ok && !req.chamber_stale;

      cls                = '0;
      cls.now_ms         = req.now_ms;
      cls.heat_switch_ok = req.heat_switch_ok;
      cls.cool_switch_ok = req.cool_switch_ok;
      cls.heat_delay_ms  = hts_pkg::DELAY_MS_W'(heat_delay_ff) *
                           hts_pkg::DELAY_MS_W'(hts_pkg::MS_PER_S);
      cls.cool_delay_ms  = hts_pkg::DELAY_MS_W'(cool_delay_ff) *
                           hts_pkg::DELAY_MS_W'(hts_pkg::MS_PER_S);
      cls.fault          = hts_pkg::FAULT_NONE;
      cls.reason         = hts_pkg::REASON_NO_CONFIG;
      cls.status         = hts_pkg::STATUS_NONE;

      if (mode_ff == hts_pkg::MODE_NONE) begin
         cls.reason = hts_pkg::REASON_NO_CONFIG;
      end else if (mode_ff != hts_pkg::MODE_THERMOSTAT) begin
         cls.fault  = hts_pkg::FAULT_MODE;
         cls.reason = hts_pkg::REASON_MODE;
      end else if (!p_present) begin
         cls.fault  = use_chamber ? hts_pkg::FAULT_CHAMBER_MISSING
                                  : hts_pkg::FAULT_BEER_MISSING;
         cls.reason = hts_pkg::REASON_MISSING;
         cls.status = hts_pkg::STATUS_FAULT;
      end else if (!p_ok) begin
         cls.fault  = use_chamber ? hts_pkg::FAULT_CHAMBER_INVALID
                                  : hts_pkg::FAULT_BEER_INVALID;
         cls.reason = hts_pkg::REASON_INVALID;
         cls.status = hts_pkg::STATUS_FAULT;
      end else if (p_stale) begin
         cls.fault  = use_chamber ? hts_pkg::FAULT_CHAMBER_STALE
                                  : hts_pkg::FAULT_BEER_STALE;
         cls.reason = hts_pkg::REASON_STALE;
         cls.status = hts_pkg::STATUS_FAULT;
      end else begin
         cls.auto_active = 1'b1;
         cls.status      = hts_pkg::STATUS_IDLE;
         cls.reason      = hts_pkg::REASON_BAND;
         // chamber too far the other way blocks the demand
         cls.heat_block  = limit_on && heat_dem && (ch_x >= (sp_x + limit_x));
         cls.cool_block  = limit_on && cool_dem && (ch_x <= (sp_x - limit_x));
         cls.heat_req    = heat_dem && !cls.heat_block;
         cls.cool_req    = cool_dem && !cls.cool_block;
      end
   end

endmodule

// ===== src/hts_back.sv =====
`timescale 1ns / 1ps
// Back end: minimum off-time checks, heat priority and relay state tracking.
// Depends on hts_pkg.
module hts_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cls_valid,
   input  hts_pkg::cls_type cls,
   output logic             cls_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output hts_pkg::rsp_type rsp
);

   logic                        heater_on_ff, heater_on_in;
   logic                        cooler_on_ff, cooler_on_in;
   logic [hts_pkg::TIME_W-1:0]  heater_off_ff, heater_off_in;
   logic [hts_pkg::TIME_W-1:0]  cooler_off_ff, cooler_off_in;

   logic                        fire;
   logic                        heat_ok;
   logic                        cool_ok;
   logic                        hc;
   logic                        cc;
   hts_pkg::status_type         status;
   hts_pkg::reason_type         reason;

   assign fire     = cls_valid && !rsp_full;
   assign cls_pop  = fire;
   assign rsp_push = fire;

   always_comb begin
      heat_ok = (cls.now_ms - heater_off_ff) >= hts_pkg::TIME_W'(cls.heat_delay_ms);
      cool_ok = (cls.now_ms - cooler_off_ff) >= hts_pkg::TIME_W'(cls.cool_delay_ms);
      status  = cls.status;
      reason  = cls.reason;
      hc      = 1'b0;
      cc      = 1'b0;

      if (cls.heat_req) begin
         if (heat_ok) begin
            hc     = 1'b1;
            status = hts_pkg::STATUS_HEATING;
            reason = hts_pkg::REASON_BELOW;
         end else begin
            reason = hts_pkg::REASON_HEAT_DELAY;
         end
      end else if (cls.heat_block) begin
         reason = hts_pkg::REASON_HIGH_LIMIT;
      end

      if (cls.cool_req) begin
         if (cool_ok) begin
            cc     = 1'b1;
            status = hts_pkg::STATUS_COOLING;
            reason = hts_pkg::REASON_ABOVE;
         end else if (!hc) begin
            reason = hts_pkg::REASON_COOL_DELAY;
         end
      end else if (cls.cool_block && !hc) begin
         reason = hts_pkg::REASON_LOW_LIMIT;
      end

      // heating wins
      if (hc && cc) begin
         cc     = 1'b0;
         status = hts_pkg::STATUS_HEATING;
         reason = hts_pkg::REASON_EXCLUSION;
      end

      // a fault leaves both commands low, so the relays simply head for off
      heater_on_in  = heater_on_ff;
      cooler_on_in  = cooler_on_ff;
      heater_off_in = heater_off_ff;
      cooler_off_in = cooler_off_ff;
      if ((hc != heater_on_ff) && cls.heat_switch_ok) begin
         heater_on_in = hc;
         if (!hc) begin
            heater_off_in = cls.now_ms;
         end
      end
      if ((cc != cooler_on_ff) && cls.cool_switch_ok) begin
         cooler_on_in = cc;
         if (!cc) begin
            cooler_off_in = cls.now_ms;
         end
      end
      if (hc && cooler_on_in && cls.cool_switch_ok) begin
         cooler_on_in  = 1'b0;
         cooler_off_in = cls.now_ms;
      end
      if (cc && heater_on_in && cls.heat_switch_ok) begin
         heater_on_in  = 1'b0;
         heater_off_in = cls.now_ms;
      end

      rsp.heat_command  = hc;
      rsp.cool_command  = cc;
      rsp.heater_active = heater_on_in;
      rsp.cooler_active = cooler_on_in;
      rsp.auto_active   = cls.auto_active;
      rsp.status_code   = status;
      rsp.reason_code   = reason;
      rsp.fault_code    = cls.fault;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heater_on_ff  <= 1'b0;
         cooler_on_ff  <= 1'b0;
         heater_off_ff <= '0;
         cooler_off_ff <= '0;
      end else if (fire) begin
         heater_on_ff  <= heater_on_in;
         cooler_on_ff  <= cooler_on_in;
         heater_off_ff <= heater_off_in;
         cooler_off_ff <= cooler_off_in;
      end
   end

endmodule

// ===== src/hysteresis_thermostat_with_delays.sv =====
`timescale 1ns / 1ps
// Top level of the hysteresis thermostat with minimum relay off-times.
// Depends on hts_pkg, hts_queue, hts_front and hts_back.
//
// Usage:
//   Input channel (req_*): one control tick per item. Present the fields with
//   req_push high; the item is taken at an edge where req_full is low.
//   Result channel (rsp_*): one result per tick, oldest first, on the rsp_
//   field ports while rsp_empty is low; take it with rsp_pop.
//   Configuration (csr_*): csr_wr_en, csr_addr and csr_wr_data write one
//   register. Write only while no tick is in flight.
// Timing:
//   The front end classifies a tick in the cycle it is taken and parks it in
//   a small queue; unless the result queue is full, the relay stage retires
//   one tick per cycle from there into the result queue, whose head shows on
//   the rsp_ ports. The block sustains one tick per cycle unless stalled.
// Reset:
//   Registers return to their reset values, both relays read off with
//   last-off times of zero, and both queues are emptied.
// Stalls:
//   If rsp_pop stays low the result queue fills, then the middle queue, and
//   req_full rises; no item is lost or reordered.
module hysteresis_thermostat_with_delays #(
   parameter int MID_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_push,
   output logic                           req_full,
   input  logic [31:0]                    req_now_ms,
   input  logic                           req_beer_present,
   input  logic                           req_beer_ok,
   input  logic                           req_beer_stale,
   input  logic signed [15:0]             req_beer_temp,
   input  logic                           req_chamber_present,
   input  logic                           req_chamber_ok,
   input  logic                           req_chamber_stale,
   input  logic signed [15:0]             req_chamber_temp,
   input  logic                           req_heat_switch_ok,
   input  logic                           req_cool_switch_ok,

   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic                           rsp_heat_command,
   output logic                           rsp_cool_command,
   output logic                           rsp_heater_active,
   output logic                           rsp_cooler_active,
   output logic                           rsp_auto_active,
   output logic [2:0]                     rsp_status_code,
   output logic [3:0]                     rsp_reason_code,
   output logic [2:0]                     rsp_fault_code,

   input  logic                           csr_wr_en,
   input  logic [hts_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [hts_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   hts_pkg::req_type req;
   hts_pkg::cls_type cls_in;
   hts_pkg::cls_type cls_head;
   hts_pkg::rsp_type rsp_new;
   hts_pkg::rsp_type rsp_head;
   logic             mid_empty;
   logic             mid_pop;
   logic             rsp_full;
   logic             rsp_push;

   always_comb begin
      req.now_ms          = req_now_ms;
      req.beer_present    = req_beer_present;
      req.beer_ok         = req_beer_ok;
      req.beer_stale      = req_beer_stale;
      req.beer_temp       = req_beer_temp;
      req.chamber_present = req_chamber_present;
      req.chamber_ok      = req_chamber_ok;
      req.chamber_stale   = req_chamber_stale;
      req.chamber_temp    = req_chamber_temp;
      req.heat_switch_ok  = req_heat_switch_ok;
      req.cool_switch_ok  = req_cool_switch_ok;
   end

   hts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .req         (req),
      .cls         (cls_in)
   );

   hts_queue #(
      .WIDTH ($bits(hts_pkg::cls_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cls_in),
      .full      (req_full),
      .pop       (mid_pop),
      .pop_data  (cls_head),
      .empty     (mid_empty)
   );

   hts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (!mid_empty),
      .cls       (cls_head),
      .cls_pop   (mid_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new)
   );

   hts_queue #(
      .WIDTH ($bits(hts_pkg::rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_heat_command  = rsp_head.heat_command;
   assign rsp_cool_command  = rsp_head.cool_command;
   assign rsp_heater_active = rsp_head.heater_active;
   assign rsp_cooler_active = rsp_head.cooler_active;
   assign rsp_auto_active   = rsp_head.auto_active;
   assign rsp_status_code   = rsp_head.status_code;
   assign rsp_reason_code   = rsp_head.reason_code;
   assign rsp_fault_code    = rsp_head.fault_code;

endmodule
